>>> design/prq_pkg.sv
// ----------------------------------------------------------------------------
// prq_pkg: shared types and constants of the priority ready queue
// Sizes, opcode and status codes, and the request, result and internal
// command formats that pass between the front queue, the engine and the
// result queue.
// ----------------------------------------------------------------------------
package prq_pkg;

	// Queue sizing and the dequeue priority limit.
	localparam int QUEUE_DEPTH    = 16;
	localparam int PRIORITY_LIMIT = 140;

	// Derived widths: slot index, held count and the limit itself.
	localparam int IDX_W   = (QUEUE_DEPTH > 2) ? $clog2(QUEUE_DEPTH) : 1;
	localparam int CNT_W   = $clog2(QUEUE_DEPTH + 1);
	localparam int LIMIT_W = 9;

	// The slot search runs per group of slots, then over the groups.
	localparam int GROUP_SIZE = 4;
	localparam int NUM_GROUPS = (QUEUE_DEPTH + GROUP_SIZE - 1) / GROUP_SIZE;
	localparam int PAD_DEPTH  = NUM_GROUPS * GROUP_SIZE;

	// Fixed field widths of the request and result.
	localparam int OPCODE_W      = 2;
	localparam int HANDLE_W      = 8;
	localparam int PRIO_W        = 8;
	localparam int STATUS_W      = 3;
	localparam int ENTRY_COUNT_W = 5;

	// Opcodes.
	localparam logic [OPCODE_W-1:0] OP_ENQUEUE = 2'd0;
	localparam logic [OPCODE_W-1:0] OP_DEQUEUE = 2'd1;
	localparam logic [OPCODE_W-1:0] OP_PURGE   = 2'd2;

	// Result status codes.
	localparam logic [STATUS_W-1:0] STATUS_OK         = 3'd0;
	localparam logic [STATUS_W-1:0] STATUS_FULL       = 3'd1;
	localparam logic [STATUS_W-1:0] STATUS_EMPTY      = 3'd2;
	localparam logic [STATUS_W-1:0] STATUS_NOT_FOUND  = 3'd3;
	localparam logic [STATUS_W-1:0] STATUS_NONE_BELOW = 3'd4;

	// One request as it arrives on the ports.
	typedef struct packed {
		logic [OPCODE_W-1:0] opcode;
		logic [HANDLE_W-1:0] proc_handle;
		logic [PRIO_W-1:0]   proc_priority;
	} request_t;

	// One result as it leaves on the ports.
	typedef struct packed {
		logic [STATUS_W-1:0]      status;
		logic [HANDLE_W-1:0]      out_handle;
		logic [PRIO_W-1:0]        out_priority;
		logic [ENTRY_COUNT_W-1:0] entry_count;
		logic                     is_empty;
	} result_t;

	// Operation class decided by the front.
	typedef enum logic [1:0] {
		KIND_ENQ,
		KIND_DEQ,
		KIND_PURGE,
		KIND_NOP
	} cmd_kind_t;

	// Classified command handed from the front to the engine.
	typedef struct packed {
		cmd_kind_t           kind;
		logic [HANDLE_W-1:0] handle;
		logic [PRIO_W-1:0]   priority_val;
	} cmd_t;

endpackage

>>> design/prq_front.sv
// ----------------------------------------------------------------------------
// prq_front: request intake and classification
// Decodes each accepted request into a command and holds it in a two-entry
// queue until the engine takes it.
// ----------------------------------------------------------------------------
module prq_front (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               push,
	output logic               full,
	input  prq_pkg::request_t  request,
	output logic               cmd_valid,
	output prq_pkg::cmd_t      cmd,
	input  logic               cmd_take
);

	prq_pkg::cmd_t decoded;
	prq_pkg::cmd_t buf_q [2];
	logic [1:0]    count_q;
	logic          wr_ptr_q;
	logic          rd_ptr_q;
	logic          do_push;
	logic          do_pop;

	// Classify the opcode; the unused code becomes a no-op.
	always_comb begin
		decoded.handle       = request.proc_handle;
		decoded.priority_val = request.proc_priority;
		case (request.opcode)
			prq_pkg::OP_ENQUEUE: decoded.kind = prq_pkg::KIND_ENQ;
			prq_pkg::OP_DEQUEUE: decoded.kind = prq_pkg::KIND_DEQ;
			prq_pkg::OP_PURGE:   decoded.kind = prq_pkg::KIND_PURGE;
			default:             decoded.kind = prq_pkg::KIND_NOP;
		endcase
	end

	assign full      = (count_q == 2'd2);
	assign cmd_valid = (count_q != 2'd0);
	assign cmd       = buf_q[rd_ptr_q];
	assign do_push   = push && !full;
	assign do_pop    = cmd_take && cmd_valid;

	// Queue pointers and fill count.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q  <= 2'd0;
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= ~wr_ptr_q;
			end
			if (do_pop) begin
				rd_ptr_q <= ~rd_ptr_q;
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + 2'd1;
			end else if (do_pop && !do_push) begin
				count_q <= count_q - 2'd1;
			end
		end
	end

	// Command storage.
	always_ff @(posedge clk) begin
		if (do_push) begin
			buf_q[wr_ptr_q] <= decoded;
		end
	end

endmodule

>>> design/prq_result_queue.sv
// ----------------------------------------------------------------------------
// prq_result_queue: two-entry result buffer
// Holds finished results until the consumer pops them, so the engine can go
// on while a result waits.
// ----------------------------------------------------------------------------
module prq_result_queue (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              res_push,
	input  prq_pkg::result_t  res_data,
	output logic              res_full,
	output logic              empty,
	input  logic              pop,
	output prq_pkg::result_t  result
);

	prq_pkg::result_t buf_q [2];
	logic [1:0]       count_q;
	logic             wr_ptr_q;
	logic             rd_ptr_q;
	logic             do_push;
	logic             do_pop;

	assign res_full = (count_q == 2'd2);
	assign empty    = (count_q == 2'd0);
	assign result   = buf_q[rd_ptr_q];
	assign do_push  = res_push && !res_full;
	assign do_pop   = pop && !empty;

	// Queue pointers and fill count.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q  <= 2'd0;
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= ~wr_ptr_q;
			end
			if (do_pop) begin
				rd_ptr_q <= ~rd_ptr_q;
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + 2'd1;
			end else if (do_pop && !do_push) begin
				count_q <= count_q - 2'd1;
			end
		end
	end

	// Result storage.
	always_ff @(posedge clk) begin
		if (do_push) begin
			buf_q[wr_ptr_q] <= res_data;
		end
	end

endmodule

>>> design/prq_engine.sv
// ----------------------------------------------------------------------------
// prq_engine: slot storage and operation engine
// Holds the slots in insertion order. A taken command is searched per group
// of slots in the issue cycle; the next cycle merges the groups, appends or
// removes with a shift-down, and pushes the result.
// ----------------------------------------------------------------------------
module prq_engine (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              cmd_valid,
	input  prq_pkg::cmd_t     cmd,
	output logic              cmd_take,
	input  logic              res_full,
	output logic              res_push,
	output prq_pkg::result_t  res_data
);

	typedef enum logic {
		S_IDLE,
		S_EXEC
	} state_t;

	state_t                       state_q;
	logic [prq_pkg::CNT_W-1:0]    count_q;
	prq_pkg::cmd_t                cmd_q;

	logic [prq_pkg::HANDLE_W-1:0] slot_handle_q [prq_pkg::QUEUE_DEPTH];
	logic [prq_pkg::PRIO_W-1:0]   slot_prio_q   [prq_pkg::QUEUE_DEPTH];

	// Padded views of the slots, so every group has a full set.
	logic [prq_pkg::HANDLE_W-1:0] pad_handle [prq_pkg::PAD_DEPTH];
	logic [prq_pkg::PRIO_W-1:0]   pad_prio   [prq_pkg::PAD_DEPTH];
	logic                         pad_live   [prq_pkg::PAD_DEPTH];

	// Per-group search results, next value and registered.
	logic                         grp_found   [prq_pkg::NUM_GROUPS];
	logic [prq_pkg::PRIO_W-1:0]   grp_prio    [prq_pkg::NUM_GROUPS];
	logic [prq_pkg::HANDLE_W-1:0] grp_handle  [prq_pkg::NUM_GROUPS];
	logic [prq_pkg::IDX_W-1:0]    grp_idx     [prq_pkg::NUM_GROUPS];
	logic                         grp_hit     [prq_pkg::NUM_GROUPS];
	logic [prq_pkg::PRIO_W-1:0]   grp_hprio   [prq_pkg::NUM_GROUPS];
	logic [prq_pkg::IDX_W-1:0]    grp_hidx    [prq_pkg::NUM_GROUPS];
	logic                         grp_found_q [prq_pkg::NUM_GROUPS];
	logic [prq_pkg::PRIO_W-1:0]   grp_prio_q  [prq_pkg::NUM_GROUPS];
	logic [prq_pkg::HANDLE_W-1:0] grp_handle_q[prq_pkg::NUM_GROUPS];
	logic [prq_pkg::IDX_W-1:0]    grp_idx_q   [prq_pkg::NUM_GROUPS];
	logic                         grp_hit_q   [prq_pkg::NUM_GROUPS];
	logic [prq_pkg::PRIO_W-1:0]   grp_hprio_q [prq_pkg::NUM_GROUPS];
	logic [prq_pkg::IDX_W-1:0]    grp_hidx_q  [prq_pkg::NUM_GROUPS];

	// Merged winners.
	logic                         min_any;
	logic [prq_pkg::PRIO_W-1:0]   low_prio;
	logic [prq_pkg::HANDLE_W-1:0] min_handle;
	logic [prq_pkg::IDX_W-1:0]    min_idx;
	logic                         hit_any;
	logic [prq_pkg::PRIO_W-1:0]   hit_prio;
	logic [prq_pkg::IDX_W-1:0]    hit_idx;

	// Execution decisions.
	logic                         do_append;
	logic                         do_remove;
	logic [prq_pkg::IDX_W-1:0]    rm_idx;
	logic [prq_pkg::CNT_W-1:0]    next_count;

	// Build the padded slot view; slots at or past the count are not live.
	for (genvar k = 0; k < prq_pkg::PAD_DEPTH; k++) begin : g_pad
		if (k < prq_pkg::QUEUE_DEPTH) begin : g_real
			assign pad_handle[k] = slot_handle_q[k];
			assign pad_prio[k]   = slot_prio_q[k];
			assign pad_live[k]   = (prq_pkg::CNT_W'(k) < count_q);
		end else begin : g_fill
			assign pad_handle[k] = '0;
			assign pad_prio[k]   = '0;
			assign pad_live[k]   = 1'b0;
		end
	end

	assign cmd_take = (state_q == S_IDLE) && cmd_valid && !res_full;

	// Group search: lowest priority below the limit (earliest wins ties) and
	// first handle match, for the command at the head of the front queue.
	always_comb begin
		logic [prq_pkg::LIMIT_W-1:0] best;
		for (int g = 0; g < prq_pkg::NUM_GROUPS; g++) begin
			best          = prq_pkg::LIMIT_W'(prq_pkg::PRIORITY_LIMIT);
			grp_found[g]  = 1'b0;
			grp_prio[g]   = '0;
			grp_handle[g] = '0;
			grp_idx[g]    = '0;
			grp_hit[g]    = 1'b0;
			grp_hprio[g]  = '0;
			grp_hidx[g]   = '0;
			for (int j = 0; j < prq_pkg::GROUP_SIZE; j++) begin
				if (pad_live[g*prq_pkg::GROUP_SIZE+j]) begin
					if ({1'b0, pad_prio[g*prq_pkg::GROUP_SIZE+j]} < best) begin
						best          = {1'b0, pad_prio[g*prq_pkg::GROUP_SIZE+j]};
						grp_found[g]  = 1'b1;
						grp_prio[g]   = pad_prio[g*prq_pkg::GROUP_SIZE+j];
						grp_handle[g] = pad_handle[g*prq_pkg::GROUP_SIZE+j];
						grp_idx[g]    = prq_pkg::IDX_W'(g*prq_pkg::GROUP_SIZE+j);
					end
					if (!grp_hit[g] && (pad_handle[g*prq_pkg::GROUP_SIZE+j] == cmd.handle)) begin
						grp_hit[g]   = 1'b1;
						grp_hprio[g] = pad_prio[g*prq_pkg::GROUP_SIZE+j];
						grp_hidx[g]  = prq_pkg::IDX_W'(g*prq_pkg::GROUP_SIZE+j);
					end
				end
			end
		end
	end

	// Merge the group winners in slot order.
	always_comb begin
		min_any    = 1'b0;
		low_prio   = '0;
		min_handle = '0;
		min_idx    = '0;
		hit_any    = 1'b0;
		hit_prio   = '0;
		hit_idx    = '0;
		for (int g = 0; g < prq_pkg::NUM_GROUPS; g++) begin
			if (grp_found_q[g] && (!min_any || (grp_prio_q[g] < low_prio))) begin
				min_any    = 1'b1;
				low_prio   = grp_prio_q[g];
				min_handle = grp_handle_q[g];
				min_idx    = grp_idx_q[g];
			end
			if (grp_hit_q[g] && !hit_any) begin
				hit_any  = 1'b1;
				hit_prio = grp_hprio_q[g];
				hit_idx  = grp_hidx_q[g];
			end
		end
	end

	// Decide the operation and form the result.
	always_comb begin
		do_append             = 1'b0;
		do_remove             = 1'b0;
		rm_idx                = '0;
		next_count            = count_q;
		res_data.status       = prq_pkg::STATUS_OK;
		res_data.out_handle   = '0;
		res_data.out_priority = '0;
		case (cmd_q.kind)
			prq_pkg::KIND_ENQ: begin
				if (count_q == prq_pkg::CNT_W'(prq_pkg::QUEUE_DEPTH)) begin
					res_data.status = prq_pkg::STATUS_FULL;
				end else begin
					do_append  = 1'b1;
					next_count = count_q + prq_pkg::CNT_W'(1);
				end
			end
			prq_pkg::KIND_DEQ: begin
				if (count_q == '0) begin
					res_data.status = prq_pkg::STATUS_EMPTY;
				end else if (!min_any) begin
					res_data.status = prq_pkg::STATUS_NONE_BELOW;
				end else begin
					do_remove             = 1'b1;
					rm_idx                = min_idx;
					next_count            = count_q - prq_pkg::CNT_W'(1);
					res_data.out_handle   = min_handle;
					res_data.out_priority = low_prio;
				end
			end
			prq_pkg::KIND_PURGE: begin
				if (count_q == '0) begin
					res_data.status = prq_pkg::STATUS_EMPTY;
				end else if (!hit_any) begin
					res_data.status = prq_pkg::STATUS_NOT_FOUND;
				end else begin
					do_remove             = 1'b1;
					rm_idx                = hit_idx;
					next_count            = count_q - prq_pkg::CNT_W'(1);
					res_data.out_handle   = cmd_q.handle;
					res_data.out_priority = hit_prio;
				end
			end
			default: begin
				next_count = count_q;
			end
		endcase
		res_data.entry_count = prq_pkg::ENTRY_COUNT_W'(next_count);
		res_data.is_empty    = (next_count == '0);
	end

	assign res_push = (state_q == S_EXEC);

	// Control state and the held count.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			count_q <= '0;
		end else begin
			case (state_q)
				S_IDLE: begin
					if (cmd_take) begin
						state_q <= S_EXEC;
					end
				end
				S_EXEC: begin
					count_q <= next_count;
					state_q <= S_IDLE;
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// Command and group search registers.
	always_ff @(posedge clk) begin
		if (cmd_take) begin
			cmd_q <= cmd;
			for (int g = 0; g < prq_pkg::NUM_GROUPS; g++) begin
				grp_found_q[g]  <= grp_found[g];
				grp_prio_q[g]   <= grp_prio[g];
				grp_handle_q[g] <= grp_handle[g];
				grp_idx_q[g]    <= grp_idx[g];
				grp_hit_q[g]    <= grp_hit[g];
				grp_hprio_q[g]  <= grp_hprio[g];
				grp_hidx_q[g]   <= grp_hidx[g];
			end
		end
	end

	// Slot storage: shift later entries down on removal, write on append.
	always_ff @(posedge clk) begin
		if (state_q == S_EXEC) begin
			if (do_remove) begin
				for (int i = 0; i < prq_pkg::QUEUE_DEPTH - 1; i++) begin
					if (prq_pkg::IDX_W'(i) >= rm_idx) begin
						slot_handle_q[i] <= slot_handle_q[i+1];
						slot_prio_q[i]   <= slot_prio_q[i+1];
					end
				end
			end
			if (do_append) begin
				slot_handle_q[count_q[prq_pkg::IDX_W-1:0]] <= cmd_q.handle;
				slot_prio_q[count_q[prq_pkg::IDX_W-1:0]]   <= cmd_q.priority_val;
			end
		end
	end

`ifndef SYNTHESIS
	// A successful enqueue grows the count by exactly one.
	assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_EXEC && cmd_q.kind == prq_pkg::KIND_ENQ &&
		 res_data.status == prq_pkg::STATUS_OK)
		|=> (count_q == $past(count_q) + prq_pkg::CNT_W'(1)))
		else $error("enqueue did not grow the count by one");

	// A successful removal shrinks the count by exactly one.
	assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_EXEC && res_data.status == prq_pkg::STATUS_OK &&
		 (cmd_q.kind == prq_pkg::KIND_DEQ || cmd_q.kind == prq_pkg::KIND_PURGE))
		|=> (count_q == $past(count_q) - prq_pkg::CNT_W'(1)))
		else $error("removal did not shrink the count by one");

	// A failed operation leaves the count untouched.
	assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_EXEC && res_data.status != prq_pkg::STATUS_OK)
		|=> $stable(count_q))
		else $error("failed operation changed the count");

	// A dequeued entry always lies below the priority limit.
	assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_EXEC && cmd_q.kind == prq_pkg::KIND_DEQ &&
		 res_data.status == prq_pkg::STATUS_OK)
		|-> ({1'b0, res_data.out_priority} <
		     prq_pkg::LIMIT_W'(prq_pkg::PRIORITY_LIMIT)))
		else $error("dequeued priority not below the limit");
`endif

endmodule

>>> design/priority_ready_queue_top.sv
// ----------------------------------------------------------------------------
// priority_ready_queue_top: bounded priority ready queue of process handles
// Request front queue, search and compaction engine, and result queue.
//
//   channel   handshake            payload
//   request   push / full          request (opcode, proc_handle, proc_priority)
//   result    pop / empty          result  (status, out_handle, out_priority,
//                                           entry_count, is_empty)
//
// The engine takes each request through an issue cycle that searches the
// slots group by group and an execute cycle that merges the groups, shifts or
// appends and pushes the result, and takes the next one only after that.
// Reset clears the counts and queue pointers; slot contents are not cleared.
// The engine waits while the result queue is full, and full rises once two
// requests wait in the front queue.
// ----------------------------------------------------------------------------
module priority_ready_queue_top (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              push,
	output logic              full,
	input  prq_pkg::request_t request,
	output logic              empty,
	input  logic              pop,
	output prq_pkg::result_t  result
);

	logic             cmd_valid;
	prq_pkg::cmd_t    cmd;
	logic             cmd_take;
	logic             res_full;
	logic             res_push;
	prq_pkg::result_t res_data;

	// Request intake and classification.
	prq_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.full      (full),
		.request   (request),
		.cmd_valid (cmd_valid),
		.cmd       (cmd),
		.cmd_take  (cmd_take)
	);

	// Slot storage and operation engine.
	prq_engine u_engine (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd_valid (cmd_valid),
		.cmd       (cmd),
		.cmd_take  (cmd_take),
		.res_full  (res_full),
		.res_push  (res_push),
		.res_data  (res_data)
	);

	// Finished results waiting for the consumer.
	prq_result_queue u_result_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.res_push (res_push),
		.res_data (res_data),
		.res_full (res_full),
		.empty    (empty),
		.pop      (pop),
		.result   (result)
	);

endmodule

>>> dv/testbench.sv
// ----------------------------------------------------------------------------
// testbench: self-checking bench for the priority ready queue
// Drives enqueue, dequeue and purge requests through the push/full side and
// checks every result popped from the empty/pop side against a scheduler
// predictor kept in step with the accepted requests. Both sides idle at
// random, and one phase holds the result side off until the block stalls.
// ----------------------------------------------------------------------------
module testbench;
	timeunit 1ns;
	timeprecision 1ps;

	import prq_pkg::*;

	// The opcode value that the block must ignore.
	localparam logic [OPCODE_W-1:0] OP_UNUSED = 2'd3;

	logic     clk;
	logic     arst_n;
	logic     push;
	logic     full;
	request_t request;
	logic     empty;
	logic     pop;
	result_t  result;

	priority_ready_queue_top dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.push    (push),
		.full    (full),
		.request (request),
		.empty   (empty),
		.pop     (pop),
		.result  (result)
	);

	// Scheduler state as the predictor sees it.
	logic [HANDLE_W-1:0] ready_handles    [QUEUE_DEPTH];
	logic [PRIO_W-1:0]   ready_priorities [QUEUE_DEPTH];
	int                  ready_count;

	// Outcomes predicted for accepted requests, oldest first.
	result_t pending_outcomes [$];
	int      mismatch_count;

	// Idling controls shared by the sender, the receiver and the tests.
	bit send_idling;
	bit recv_idling;
	int hold_off_cycles;

	always begin
		clk = 1'b0;
		#1;
		clk = 1'b1;
		#1;
	end

	// Apply one request to the predicted scheduler and return its outcome.
	function automatic result_t schedule_outcome(request_t req);
		result_t outcome;
		int      pos;
		int      best;
		int      i;
		outcome = '0;
		outcome.status = STATUS_OK;
		pos = -1;
		case (req.opcode)
			OP_ENQUEUE: begin
				if (ready_count >= QUEUE_DEPTH) begin
					outcome.status = STATUS_FULL;
				end else begin
					ready_handles[ready_count] = req.proc_handle;
					ready_priorities[ready_count] = req.proc_priority;
					ready_count++;
				end
			end
			OP_DEQUEUE: begin
				if (ready_count == 0) begin
					outcome.status = STATUS_EMPTY;
				end else begin
					// Strictly lower wins, so the earliest entry keeps a tie.
					best = PRIORITY_LIMIT;
					for (i = 0; i < ready_count; i++) begin
						if (int'(ready_priorities[i]) < best) begin
							best = int'(ready_priorities[i]);
							pos = i;
						end
					end
					if (pos < 0)
						outcome.status = STATUS_NONE_BELOW;
				end
			end
			OP_PURGE: begin
				if (ready_count == 0) begin
					outcome.status = STATUS_EMPTY;
				end else begin
					for (i = 0; i < ready_count; i++) begin
						if (pos < 0 && ready_handles[i] == req.proc_handle)
							pos = i;
					end
					if (pos < 0)
						outcome.status = STATUS_NOT_FOUND;
				end
			end
			default: ;
		endcase
		// A removal closes the gap and keeps insertion order.
		if (pos >= 0) begin
			outcome.out_handle = ready_handles[pos];
			outcome.out_priority = ready_priorities[pos];
			for (i = pos; i < ready_count - 1; i++) begin
				ready_handles[i] = ready_handles[i + 1];
				ready_priorities[i] = ready_priorities[i + 1];
			end
			ready_count--;
		end
		outcome.entry_count = ENTRY_COUNT_W'(ready_count);
		outcome.is_empty = (ready_count == 0);
		return outcome;
	endfunction

	function automatic request_t make_request(logic [OPCODE_W-1:0] opcode,
			logic [HANDLE_W-1:0] handle, logic [PRIO_W-1:0] prio);
		request_t req;
		req.opcode = opcode;
		req.proc_handle = handle;
		req.proc_priority = prio;
		return req;
	endfunction

	// Random request; purges mostly name a handle that is held, and a
	// narrow handle range makes duplicates common.
	function automatic request_t random_request(int enqueue_pct);
		request_t req;
		int       roll;
		roll = $urandom_range(0, 99);
		if ($urandom_range(0, 19) == 0)
			req.opcode = OP_UNUSED;
		else if (roll < enqueue_pct)
			req.opcode = OP_ENQUEUE;
		else
			req.opcode = $urandom_range(0, 1) ? OP_DEQUEUE : OP_PURGE;
		if ($urandom_range(0, 3) == 0)
			req.proc_handle = HANDLE_W'($urandom_range(0, 7));
		else
			req.proc_handle = HANDLE_W'($urandom_range(0, 255));
		if (req.opcode == OP_PURGE && ready_count > 0 && $urandom_range(0, 3) != 0)
			req.proc_handle = ready_handles[$urandom_range(0, ready_count - 1)];
		case ($urandom_range(0, 3))
			0, 1: req.proc_priority = PRIO_W'($urandom_range(0, 255));
			2: req.proc_priority = PRIO_W'($urandom_range(PRIORITY_LIMIT - 10,
				PRIORITY_LIMIT + 10));
			default: begin
				case ($urandom_range(0, 3))
					0: req.proc_priority = 8'd0;
					1: req.proc_priority = PRIO_W'(PRIORITY_LIMIT - 1);
					2: req.proc_priority = PRIO_W'(PRIORITY_LIMIT);
					default: req.proc_priority = 8'd255;
				endcase
			end
		endcase
		return req;
	endfunction

	// Offer one request. Called just after a falling edge and returns just
	// after one, with push left high so back-to-back requests keep it high.
	task automatic send_request(request_t req);
		int gap;
		gap = send_idling ? $urandom_range(0, 18) : 0;
		if (gap > 0) begin
			push = 1'b0;
			repeat (gap) @(negedge clk);
		end
		push = 1'b1;
		request = req;
		do @(posedge clk); while (full);
		pending_outcomes.push_back(schedule_outcome(req));
		@(negedge clk);
	endtask

	// Compare one popped result with the oldest predicted outcome.
	task automatic check_outcome(result_t got);
		result_t want;
		if (pending_outcomes.size() == 0) begin
			$error("result with no request waiting: %h", got);
			mismatch_count++;
			return;
		end
		want = pending_outcomes.pop_front();
		if (got.status !== want.status) begin
			$error("status: expected %0d, got %0d", want.status, got.status);
			mismatch_count++;
		end
		if (got.out_handle !== want.out_handle) begin
			$error("out_handle: expected %h, got %h", want.out_handle, got.out_handle);
			mismatch_count++;
		end
		if (got.out_priority !== want.out_priority) begin
			$error("out_priority: expected %0d, got %0d", want.out_priority,
				got.out_priority);
			mismatch_count++;
		end
		if (got.entry_count !== want.entry_count) begin
			$error("entry_count: expected %0d, got %0d", want.entry_count,
				got.entry_count);
			mismatch_count++;
		end
		if (got.is_empty !== want.is_empty) begin
			$error("is_empty: expected %b, got %b", want.is_empty, got.is_empty);
			mismatch_count++;
		end
	endtask

	// Result side: optional long hold-off, a random stall, then pop one.
	initial begin : result_receiver
		int gap;
		pop = 1'b0;
		wait (arst_n === 1'b1);
		@(negedge clk);
		forever begin
			if (hold_off_cycles > 0) begin
				pop = 1'b0;
				repeat (hold_off_cycles) @(negedge clk);
				hold_off_cycles = 0;
			end
			gap = recv_idling ? $urandom_range(0, 18) : 0;
			if (gap > 0) begin
				pop = 1'b0;
				repeat (gap) @(negedge clk);
			end
			pop = 1'b1;
			do @(posedge clk); while (empty);
			check_outcome(result);
			@(negedge clk);
		end
	end

	// Every special case on an empty, partly filled and full queue.
	task automatic test_directed_cases();
		int i;
		send_idling = 1'b1;
		recv_idling = 1'b1;
		send_request(make_request(OP_DEQUEUE, 8'h00, 8'h00));
		send_request(make_request(OP_PURGE, 8'h12, 8'h00));
		send_request(make_request(OP_UNUSED, 8'hFF, 8'hFF));
		send_request(make_request(OP_ENQUEUE, 8'h00, 8'd0));
		send_request(make_request(OP_ENQUEUE, 8'hFF, 8'd255));
		send_request(make_request(OP_ENQUEUE, 8'h5A, PRIO_W'(PRIORITY_LIMIT - 1)));
		send_request(make_request(OP_ENQUEUE, 8'hA5, PRIO_W'(PRIORITY_LIMIT)));
		send_request(make_request(OP_ENQUEUE, 8'h33, PRIO_W'(PRIORITY_LIMIT - 1)));
		// Fill to the top; the first filler repeats a handle and a priority.
		for (i = 0; i < QUEUE_DEPTH - 5; i++) begin
			if (i == 0)
				send_request(make_request(OP_ENQUEUE, 8'h5A,
					PRIO_W'(PRIORITY_LIMIT - 1)));
			else
				send_request(make_request(OP_ENQUEUE, HANDLE_W'(8'h80 + i),
					PRIO_W'(PRIORITY_LIMIT + i * 11)));
		end
		send_request(make_request(OP_ENQUEUE, 8'hC3, 8'd0));
		send_request(make_request(OP_PURGE, 8'h77, 8'h00));
		send_request(make_request(OP_PURGE, 8'hA5, 8'h00));
		send_request(make_request(OP_PURGE, 8'h5A, 8'h00));
		// Lowest first, then a tie that the earlier entry must win.
		send_request(make_request(OP_DEQUEUE, 8'hEE, 8'h01));
		send_request(make_request(OP_DEQUEUE, 8'h00, 8'h00));
		send_request(make_request(OP_DEQUEUE, 8'h00, 8'h00));
		send_request(make_request(OP_DEQUEUE, 8'h00, 8'h00));
	endtask

	// Random traffic in chunks that lean to filling or to draining, each
	// with its own idling choice on both sides.
	task automatic test_random_traffic(int count);
		int i;
		int enqueue_pct;
		for (i = 0; i < count; i++) begin
			if (i % 40 == 0) begin
				enqueue_pct = ((i / 40) % 2 == 0) ? 75 : 25;
				send_idling = 1'($urandom_range(0, 1));
				recv_idling = 1'($urandom_range(0, 1));
			end
			send_request(random_request(enqueue_pct));
		end
	endtask

	// No idling on either side: requests and pops every cycle while full and empty allow.
	task automatic test_back_to_back(int count);
		int i;
		send_idling = 1'b0;
		recv_idling = 1'b0;
		for (i = 0; i < count; i++)
			send_request(random_request(50));
	endtask

	// The receiver stops for a long stretch while requests keep coming, so
	// the result queue and then the front queue fill and full rises.
	task automatic test_receiver_hold_off(int count);
		int i;
		send_idling = 1'b0;
		recv_idling = 1'b0;
		hold_off_cycles = 150;
		for (i = 0; i < count; i++) begin
			if (i == count / 2) begin
				send_idling = 1'b1;
				recv_idling = 1'b1;
			end
			send_request(random_request(60));
		end
	endtask

	initial begin : stimulus
		int wait_cycles;
		arst_n = 1'b0;
		push = 1'b0;
		request = '0;
		send_idling = 1'b0;
		recv_idling = 1'b0;
		hold_off_cycles = 0;
		mismatch_count = 0;
		ready_count = 0;
		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		test_directed_cases();
		test_random_traffic(260);
		test_back_to_back(120);
		test_receiver_hold_off(80);
		push = 1'b0;

		// Drain what is still in flight, then watch for stray results.
		wait_cycles = 0;
		while (pending_outcomes.size() != 0 && wait_cycles < 20000) begin
			@(posedge clk);
			wait_cycles++;
		end
		if (pending_outcomes.size() != 0) begin
			$error("%0d results never arrived", pending_outcomes.size());
			mismatch_count++;
		end
		repeat (20) @(posedge clk);

		if (mismatch_count == 0)
			$display("== PASS ==");
		else
			$display("== FAIL ==");
		$finish;
	end

	// Run limit, well above the slowest correct run.
	initial begin : run_limit
		#1000000;
		$display("== FAIL ==");
		$finish;
	end

endmodule
